// ===== rtl/spa_pkg.sv =====
// Shared types and constants for the sparse polynomial adder.
// Depends on nothing; used by every other file of the block.
`timescale 1ns / 1ps
`default_nettype none

package spa_pkg;

  localparam int COEF_W        = 32;
  localparam int EXP_W         = 16;
  localparam int OP_W          = 2;
  localparam int MAX_TERMS_DEF = 16;

  localparam logic [OP_W-1:0] OP_LOAD_A = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD_B = 2'd1;
  localparam logic [OP_W-1:0] OP_MERGE  = 2'd2;

  typedef struct packed {
    logic load_a;
    logic load_b;
    logic rd;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic fin;
  } stat_t;

endpackage

`default_nettype wire

// ===== rtl/sparse_polynomial_add.sv =====
// Sparse polynomial adder, top level: controller plus datapath.
// Load words give no result. A merge word gives its results one at a time,
// each from one store read then one compare/add; busy stays high through the
// walk and falls as the last result appears.
// Results cannot be stalled. Reset empties both stores and clears the drop flag.
`timescale 1ns / 1ps
`default_nettype none

module sparse_polynomial_add #(
  parameter int MAX_TERMS = spa_pkg::MAX_TERMS_DEF
) (
  input  wire                                     clk,
  input  wire                                     rst,
  input  wire                                     start,
  output logic                                    busy,
  input  wire logic [spa_pkg::OP_W-1:0]           operation,
  input  wire logic signed [spa_pkg::COEF_W-1:0]  coef_in,
  input  wire logic [spa_pkg::EXP_W-1:0]          exp_in,
  output logic                                    strobe,
  output logic signed [spa_pkg::COEF_W-1:0]       coef_out,
  output logic [spa_pkg::EXP_W-1:0]               exp_out,
  output logic                                    term_valid,
  output logic                                    last,
  output logic                                    dropped
);

  spa_pkg::cmd_t  cmd;
  spa_pkg::stat_t stat;

  spa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .operation (operation),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy)
  );

  spa_dp #(
    .MAX_TERMS (MAX_TERMS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .coef_in    (coef_in),
    .exp_in     (exp_in),
    .strobe     (strobe),
    .coef_out   (coef_out),
    .exp_out    (exp_out),
    .term_valid (term_valid),
    .last       (last),
    .dropped    (dropped)
  );

endmodule

`default_nettype wire

// ===== rtl/spa_dp.sv =====
// Datapath: both term stores, counts, drop flag, walk pointers, merge step.
// Depends on spa_pkg; driven by spa_ctrl through cmd_t, reports stat_t.
`timescale 1ns / 1ps
`default_nettype none

module spa_dp #(
  parameter int MAX_TERMS = spa_pkg::MAX_TERMS_DEF
) (
  input  wire                               clk,
  input  wire                               rst,
  input  spa_pkg::cmd_t                     cmd,
  output spa_pkg::stat_t                    stat,
  input  wire logic signed [spa_pkg::COEF_W-1:0] coef_in,
  input  wire logic [spa_pkg::EXP_W-1:0]    exp_in,
  output logic                              strobe,
  output logic signed [spa_pkg::COEF_W-1:0] coef_out,
  output logic [spa_pkg::EXP_W-1:0]         exp_out,
  output logic                              term_valid,
  output logic                              last,
  output logic                              dropped
);

  localparam int CNT_W  = $clog2(MAX_TERMS + 1);
  localparam int IDX_W  = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int TERM_W = spa_pkg::COEF_W + spa_pkg::EXP_W;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_TERMS);

  logic [TERM_W-1:0] mem_a [MAX_TERMS];
  logic [TERM_W-1:0] mem_b [MAX_TERMS];
  logic [TERM_W-1:0] rd_a;
  logic [TERM_W-1:0] rd_b;

  logic [CNT_W-1:0] cnt_a;
  logic [CNT_W-1:0] cnt_b;
  logic [CNT_W-1:0] i;
  logic [CNT_W-1:0] j;
  logic [CNT_W-1:0] i_next;
  logic [CNT_W-1:0] j_next;
  logic             overflow;

  logic a_left, b_left, adv_i, adv_j, fin;
  logic signed [spa_pkg::COEF_W-1:0] a_coef, b_coef, res_coef;
  logic [spa_pkg::EXP_W-1:0]         a_exp, b_exp, res_exp;
  logic [spa_pkg::COEF_W:0]          sum;
  logic                              res_valid;

  assign a_coef = $signed(rd_a[TERM_W-1 -: spa_pkg::COEF_W]);
  assign a_exp  = rd_a[spa_pkg::EXP_W-1:0];
  assign b_coef = $signed(rd_b[TERM_W-1 -: spa_pkg::COEF_W]);
  assign b_exp  = rd_b[spa_pkg::EXP_W-1:0];
  assign a_left = (i < cnt_a);
  assign b_left = (j < cnt_b);
  assign sum    = {a_coef[spa_pkg::COEF_W-1], a_coef} + {b_coef[spa_pkg::COEF_W-1], b_coef};

  always_comb begin
    adv_i     = 1'b0;
    adv_j     = 1'b0;
    res_coef  = '0;
    res_exp   = '0;
    res_valid = 1'b1;
    if (a_left && b_left) begin
      if (a_exp == b_exp) begin
        adv_i   = 1'b1;
        adv_j   = 1'b1;
        res_exp = a_exp;
        if (sum[spa_pkg::COEF_W] != sum[spa_pkg::COEF_W-1]) begin
          res_coef = sum[spa_pkg::COEF_W] ? {1'b1, {(spa_pkg::COEF_W-1){1'b0}}}
                                          : {1'b0, {(spa_pkg::COEF_W-1){1'b1}}};
        end else begin
          res_coef = sum[spa_pkg::COEF_W-1:0];
        end
      end else if (a_exp > b_exp) begin
        adv_i    = 1'b1;
        res_coef = a_coef;
        res_exp  = a_exp;
      end else begin
        adv_j    = 1'b1;
        res_coef = b_coef;
        res_exp  = b_exp;
      end
    end else if (a_left) begin
      adv_i    = 1'b1;
      res_coef = a_coef;
      res_exp  = a_exp;
    end else if (b_left) begin
      adv_j    = 1'b1;
      res_coef = b_coef;
      res_exp  = b_exp;
    end else begin
      res_valid = 1'b0;
    end
    i_next = i + CNT_W'(adv_i);
    j_next = j + CNT_W'(adv_j);
    fin    = (i_next == cnt_a) && (j_next == cnt_b);
  end

  assign stat.fin = fin;

  // stores: write on load, registered read for the walk
  always_ff @(posedge clk) begin
    if (cmd.load_a && (cnt_a < CNT_MAX)) begin
      mem_a[cnt_a[IDX_W-1:0]] <= {coef_in, exp_in};
    end
    if (cmd.load_b && (cnt_b < CNT_MAX)) begin
      mem_b[cnt_b[IDX_W-1:0]] <= {coef_in, exp_in};
    end
    if (cmd.rd && a_left) begin
      rd_a <= mem_a[i[IDX_W-1:0]];
    end
    if (cmd.rd && b_left) begin
      rd_b <= mem_b[j[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_a    <= '0;
      cnt_b    <= '0;
      i        <= '0;
      j        <= '0;
      overflow <= 1'b0;
      strobe   <= 1'b0;
    end else begin
      strobe <= cmd.emit;
      if (cmd.load_a) begin
        if (cnt_a < CNT_MAX) begin
          cnt_a <= cnt_a + CNT_W'(1);
        end else begin
          overflow <= 1'b1;
        end
      end
      if (cmd.load_b) begin
        if (cnt_b < CNT_MAX) begin
          cnt_b <= cnt_b + CNT_W'(1);
        end else begin
          overflow <= 1'b1;
        end
      end
      if (cmd.emit) begin
        if (fin) begin
          cnt_a    <= '0;
          cnt_b    <= '0;
          i        <= '0;
          j        <= '0;
          overflow <= 1'b0;
        end else begin
          i <= i_next;
          j <= j_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      coef_out   <= res_coef;
      exp_out    <= res_exp;
      term_valid <= res_valid;
      last       <= fin;
      dropped    <= overflow;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/spa_ctrl.sv =====
// Controller: decodes commands and sequences the read/emit merge walk.
// Depends on spa_pkg; drives spa_dp through cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module spa_ctrl (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         start,
  input  wire logic [spa_pkg::OP_W-1:0] operation,
  input  spa_pkg::stat_t              stat,
  output spa_pkg::cmd_t               cmd,
  output logic                        busy
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_EMIT = 3'b100
  } state_t;

  state_t state, state_next;
  logic   take;

  assign busy = (state != S_IDLE);
  assign take = start && !busy;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (take) begin
          case (operation)
            spa_pkg::OP_LOAD_A: cmd.load_a = 1'b1;
            spa_pkg::OP_LOAD_B: cmd.load_b = 1'b1;
            spa_pkg::OP_MERGE:  state_next = S_READ;
            default:            ;
          endcase
        end
      end
      S_READ: begin
        cmd.rd     = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        cmd.emit   = 1'b1;
        state_next = stat.fin ? S_IDLE : S_READ;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/spa_checker.sv =====
// Port-level checks for the sparse polynomial adder, bound to the top level.
// Depends on spa_pkg and sparse_polynomial_add.
`timescale 1ns / 1ps
`default_nettype none

module spa_port_checks (
  input wire                          clk,
  input wire                          rst,
  input wire                          start,
  input wire                          busy,
  input wire [spa_pkg::OP_W-1:0]      operation,
  input wire                          strobe,
  input wire                          term_valid,
  input wire                          last
);

  a_merge_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (operation == spa_pkg::OP_MERGE) |=> busy)
    else $error("merge word accepted but block not busy");

  a_more_busy: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |-> busy)
    else $error("non-final word while idle");

  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    strobe && !term_valid |-> last)
    else $error("empty result not marked last");

  a_spacing: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |=> !strobe)
    else $error("result words closer than two cycles");

endmodule

bind sparse_polynomial_add spa_port_checks u_spa_port_checks (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .operation  (operation),
  .strobe     (strobe),
  .term_valid (term_valid),
  .last       (last)
);

`default_nettype wire
